// ===== rtl/vlsc_pkg.sv =====
package vlsc_pkg;

  localparam int unsigned CapacityDefault = 64;

  localparam int unsigned OpW     = 2;
  localparam int unsigned TagW    = 64;
  localparam int unsigned SizeW   = 64;
  localparam int unsigned TrackW  = 16;
  localparam int unsigned RecordW = 8;
  localparam int unsigned WordW   = 32;
  localparam int unsigned StatusW = 2;

  typedef enum logic [OpW-1:0] {
    OP_LOOKUP     = 2'd0,
    OP_PUT        = 2'd1,
    OP_GET        = 2'd2,
    OP_INVALIDATE = 2'd3
  } op_t;

  localparam logic [StatusW-1:0] ST_OK    = 2'd0;
  localparam logic [StatusW-1:0] ST_MISS  = 2'd1;
  localparam logic [StatusW-1:0] ST_STALE = 2'd2;

  // one slot's payload, kept in a single memory word
  typedef struct packed {
    logic [TagW-1:0]    dataset;
    logic [TagW-1:0]    member;
    logic [SizeW-1:0]   size;
    logic [TrackW-1:0]  track;
    logic [RecordW-1:0] record;
    logic [WordW-1:0]   lines;
    logic [WordW-1:0]   date;
  } entry_t;

endpackage

// ===== rtl/validated_lru_size_cache_unit.sv =====
// flow: a key match scan of the entry memory, then, for a put that misses with no free slot,
// a scan of the stamp memory and eviction of the victim, then the update and the result beat
// throughput: one item at a time; in_ready is low until the result beat leaves,
// set by the entry and stamp memories, which a scan reads one slot per cycle
// reset: used bits and occupancy cleared at once, no sweep
module validated_lru_size_cache_unit #(
  parameter int unsigned CAPACITY = vlsc_pkg::CapacityDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [63:0] in_dataset_tag,
  input  logic [63:0] in_member_tag,
  input  logic [63:0] in_size_value,
  input  logic [15:0] in_first_track,
  input  logic [7:0]  in_first_record,
  input  logic signed [31:0] in_line_count,
  input  logic signed [31:0] in_change_date,
  input  logic [31:0] in_now_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [63:0] out_cached_size,
  output logic [15:0] out_cached_track,
  output logic [7:0]  out_cached_record,
  output logic signed [31:0] out_cached_lines,
  output logic signed [31:0] out_cached_date,
  output logic [6:0]  out_entry_count
);

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(CAPACITY - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_LRU, S_FREE, S_ACT, S_OUT
  } state_t;

  state_t state_r;

  // request held for the whole operation
  vlsc_pkg::op_t    op_r;
  vlsc_pkg::entry_t req_r;
  logic [31:0]      now_r;

  // memories
  vlsc_pkg::entry_t ent_mem [CAPACITY];
  logic [31:0]      stamp_mem [CAPACITY];
  logic [CAPACITY-1:0] used_r;
  logic [CntW-1:0]  occ_r;

  // scan state
  logic [IdxW-1:0] idx_r;       // address being read
  logic            rd_vld_r;    // read data valid this cycle
  logic [IdxW-1:0] rd_idx_r;    // address of read data
  logic            last_r;      // read data is the last slot
  vlsc_pkg::entry_t ent_q_r;
  logic [31:0]      stamp_q_r;
  logic            hit_r;
  logic [IdxW-1:0] hit_idx_r;
  vlsc_pkg::entry_t hit_ent_r;
  logic [31:0]     min_r;
  logic [IdxW-1:0] vic_r;
  logic            free_fnd;
  logic [IdxW-1:0] free_idx;

  // result registers
  logic [1:0]  st_r;
  vlsc_pkg::entry_t res_r;

  // memory write port
  logic             wr_en;
  logic [IdxW-1:0]  wr_idx;
  logic             sw_en;
  logic [IdxW-1:0]  sw_idx;
  logic [31:0]      sw_val;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_status        = st_r;
  assign out_cached_size   = res_r.size;
  assign out_cached_track  = res_r.track;
  assign out_cached_record = res_r.record;
  assign out_cached_lines  = res_r.lines;
  assign out_cached_date   = res_r.date;
  assign out_entry_count   = 7'(occ_r);

  // lowest free slot via priority search over the used bits
  always_comb begin
    free_fnd = 1'b0;
    free_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_fnd = 1'b1;
        free_idx = IdxW'(i);
      end
    end
  end

  // memory read and write
  always_ff @(posedge clk) begin
    ent_q_r   <= ent_mem[idx_r];
    stamp_q_r <= stamp_mem[idx_r];
    if (wr_en) ent_mem[wr_idx] <= req_r;
    if (sw_en) stamp_mem[sw_idx] <= sw_val;
  end

  // write decisions taken in the action state
  logic key_eq, chk_eq;
  always_comb begin
    key_eq = (ent_q_r.dataset == req_r.dataset) && (ent_q_r.member == req_r.member);
    chk_eq = (hit_ent_r.lines == req_r.lines) && (hit_ent_r.date == req_r.date) &&
             (hit_ent_r.track == req_r.track) && (hit_ent_r.record == req_r.record);
    wr_en  = 1'b0;
    wr_idx = hit_idx_r;
    sw_en  = 1'b0;
    sw_idx = hit_idx_r;
    sw_val = now_r;
    if (state_r == S_ACT) begin
      unique case (op_r)
        vlsc_pkg::OP_LOOKUP: begin
          sw_en  = hit_r;
          sw_val = chk_eq ? now_r : '0;
        end
        vlsc_pkg::OP_PUT: begin
          wr_en = 1'b1;
          sw_en = 1'b1;
          if (!hit_r) begin
            wr_idx = free_fnd ? free_idx : vic_r;
            sw_idx = wr_idx;
          end
        end
        vlsc_pkg::OP_GET: ;
        vlsc_pkg::OP_INVALIDATE: begin
          sw_en  = hit_r;
          sw_val = '0;
        end
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      used_r   <= '0;
      occ_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r          <= vlsc_pkg::op_t'(in_op);
            req_r.dataset <= in_dataset_tag;
            req_r.member  <= in_member_tag;
            req_r.size    <= in_size_value;
            req_r.track   <= in_first_track;
            req_r.record  <= in_first_record;
            req_r.lines   <= in_line_count;
            req_r.date    <= in_change_date;
            now_r         <= in_now_seconds;
            idx_r         <= '0;
            rd_vld_r      <= 1'b0;
            hit_r         <= 1'b0;
            state_r       <= S_SCAN;
          end
        end
        // key match scan, one slot per cycle
        S_SCAN: begin
          rd_vld_r <= 1'b1;
          rd_idx_r <= idx_r;
          last_r   <= (idx_r == LastIdx);
          if (idx_r != LastIdx) idx_r <= idx_r + 1'b1;
          if (rd_vld_r) begin
            if (used_r[rd_idx_r] && key_eq && !hit_r) begin
              hit_r     <= 1'b1;
              hit_idx_r <= rd_idx_r;
              hit_ent_r <= ent_q_r;
            end
            if (last_r) begin
              rd_vld_r <= 1'b0;
              idx_r    <= '0;
              if (op_r == vlsc_pkg::OP_PUT && !(hit_r || (used_r[rd_idx_r] && key_eq))
                  && !free_fnd)
                state_r <= S_LRU;
              else
                state_r <= S_ACT;
            end
          end
        end
        // oldest stamp search, lowest index wins ties
        S_LRU: begin
          rd_vld_r <= 1'b1;
          rd_idx_r <= idx_r;
          last_r   <= (idx_r == LastIdx);
          if (idx_r != LastIdx) idx_r <= idx_r + 1'b1;
          if (rd_vld_r) begin
            if (rd_idx_r == '0 || stamp_q_r < min_r) begin
              min_r <= stamp_q_r;
              vic_r <= rd_idx_r;
            end
            if (last_r) begin
              rd_vld_r <= 1'b0;
              state_r  <= S_FREE;
            end
          end
        end
        // evict the victim before reuse
        S_FREE: begin
          used_r[vic_r] <= 1'b0;
          occ_r         <= occ_r - 1'b1;
          state_r       <= S_ACT;
        end
        S_ACT: begin
          st_r  <= vlsc_pkg::ST_MISS;
          res_r <= '0;
          unique case (op_r)
            vlsc_pkg::OP_LOOKUP: begin
              if (hit_r) begin
                if (chk_eq) begin
                  st_r       <= vlsc_pkg::ST_OK;
                  res_r.size <= hit_ent_r.size;
                end else begin
                  st_r <= vlsc_pkg::ST_STALE;
                  used_r[hit_idx_r] <= 1'b0;
                  occ_r <= occ_r - 1'b1;
                end
              end
            end
            vlsc_pkg::OP_PUT: begin
              st_r <= vlsc_pkg::ST_OK;
              if (!hit_r) begin
                used_r[wr_idx] <= 1'b1;
                if (occ_r != CapCnt) occ_r <= occ_r + 1'b1;
              end
            end
            vlsc_pkg::OP_GET: begin
              if (hit_r) begin
                st_r         <= vlsc_pkg::ST_OK;
                res_r.size   <= hit_ent_r.size;
                res_r.track  <= hit_ent_r.track;
                res_r.record <= hit_ent_r.record;
                res_r.lines  <= hit_ent_r.lines;
                res_r.date   <= hit_ent_r.date;
              end
            end
            vlsc_pkg::OP_INVALIDATE: begin
              if (hit_r) begin
                st_r <= vlsc_pkg::ST_OK;
                used_r[hit_idx_r] <= 1'b0;
                occ_r <= occ_r - 1'b1;
              end
            end
            default: ;
          endcase
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== verif/tb.sv =====
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Slots = vlsc_pkg::CapacityDefault;
  localparam int unsigned IdleLimit = 20000;

  typedef struct packed {
    vlsc_pkg::op_t op;
    logic [63:0]  dataset;
    logic [63:0]  member;
    logic [63:0]  size;
    logic [15:0]  track;
    logic [7:0]   record;
    logic [31:0]  lines;
    logic [31:0]  date;
    logic [31:0]  now;
  } request_t;

  typedef struct packed {
    logic [1:0]   status;
    logic [63:0]  size;
    logic [15:0]  track;
    logic [7:0]   record;
    logic [31:0]  lines;
    logic [31:0]  date;
    logic [6:0]   count;
  } reply_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [1:0] in_op;
  logic [63:0] in_dataset_tag;
  logic [63:0] in_member_tag;
  logic [63:0] in_size_value;
  logic [15:0] in_first_track;
  logic [7:0] in_first_record;
  logic signed [31:0] in_line_count;
  logic signed [31:0] in_change_date;
  logic [31:0] in_now_seconds;
  logic out_valid;
  logic out_ready;
  logic [1:0] out_status;
  logic [63:0] out_cached_size;
  logic [15:0] out_cached_track;
  logic [7:0] out_cached_record;
  logic signed [31:0] out_cached_lines;
  logic signed [31:0] out_cached_date;
  logic [6:0] out_entry_count;

  validated_lru_size_cache_unit u_top (.*);

  // shadow copy of the cache contents
  logic              shadow_used [Slots];
  vlsc_pkg::entry_t  shadow_entry [Slots];
  logic [31:0]       shadow_stamp [Slots];
  int unsigned       shadow_count;

  request_t pending_reqs [$];
  reply_t   expected_replies [$];
  int unsigned errors;
  bit stimulus_done;

  // key pool kept small so that hits and evictions are common
  logic [63:0] ds_pool [8];
  logic [63:0] mem_pool [16];

  function automatic int find_slot(logic [63:0] ds, logic [63:0] mem);
    for (int i = 0; i < Slots; i++)
      if (shadow_used[i] && shadow_entry[i].dataset == ds && shadow_entry[i].member == mem)
        return i;
    return -1;
  endfunction

  function automatic void drop_slot(int i);
    shadow_used[i] = 1'b0;
    shadow_stamp[i] = '0;
    if (shadow_count > 0) shadow_count--;
  endfunction

  function automatic int take_slot();
    int victim;
    victim = 0;
    for (int i = 0; i < Slots; i++)
      if (!shadow_used[i]) return i;
    for (int i = 1; i < Slots; i++)
      if (shadow_stamp[i] < shadow_stamp[victim]) victim = i;
    drop_slot(victim);
    return victim;
  endfunction

  function automatic reply_t cache_response(request_t r);
    reply_t rsp;
    int idx;
    rsp = '0;
    rsp.status = vlsc_pkg::ST_MISS;
    idx = find_slot(r.dataset, r.member);
    case (r.op)
      vlsc_pkg::OP_LOOKUP: begin
        if (idx >= 0) begin
          if (shadow_entry[idx].lines == r.lines && shadow_entry[idx].date == r.date &&
              shadow_entry[idx].track == r.track && shadow_entry[idx].record == r.record) begin
            rsp.status = vlsc_pkg::ST_OK;
            rsp.size = shadow_entry[idx].size;
            shadow_stamp[idx] = r.now;
          end else begin
            drop_slot(idx);
            rsp.status = vlsc_pkg::ST_STALE;
          end
        end
      end
      vlsc_pkg::OP_PUT: begin
        if (idx < 0) begin
          idx = take_slot();
          shadow_used[idx] = 1'b1;
          shadow_count++;
        end
        shadow_entry[idx] = '{r.dataset, r.member, r.size, r.track, r.record, r.lines, r.date};
        shadow_stamp[idx] = r.now;
        rsp.status = vlsc_pkg::ST_OK;
      end
      vlsc_pkg::OP_GET: begin
        if (idx >= 0) begin
          rsp.status = vlsc_pkg::ST_OK;
          rsp.size = shadow_entry[idx].size;
          rsp.track = shadow_entry[idx].track;
          rsp.record = shadow_entry[idx].record;
          rsp.lines = shadow_entry[idx].lines;
          rsp.date = shadow_entry[idx].date;
        end
      end
      default: begin
        if (idx >= 0) begin
          drop_slot(idx);
          rsp.status = vlsc_pkg::ST_OK;
        end
      end
    endcase
    rsp.count = shadow_count[6:0];
    return rsp;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic request_t random_request(logic [31:0] now);
    request_t r;
    r.op = vlsc_pkg::op_t'($urandom_range(3, 0));
    r.dataset = ds_pool[$urandom_range(7, 0)];
    r.member = mem_pool[$urandom_range(15, 0)];
    r.size = rand64();
    // validity fields from a narrow set most of the time so lookups can hit
    if ($urandom_range(3, 0) != 0) begin
      r.track = 16'($urandom_range(1, 0));
      r.record = 8'($urandom_range(1, 0));
      r.lines = 32'($urandom_range(1, 0));
      r.date = 32'($urandom_range(1, 0));
    end else begin
      r.track = 16'($urandom());
      r.record = 8'($urandom());
      r.lines = $urandom();
      r.date = $urandom();
    end
    r.now = now;
    return r;
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // stimulus
  initial begin
    request_t r;
    logic [31:0] clock_now;
    rst_n = 1'b0;
    stimulus_done = 1'b0;
    for (int i = 0; i < 8; i++) ds_pool[i] = rand64();
    for (int i = 0; i < 16; i++) mem_pool[i] = rand64();
    ds_pool[0] = '0;
    ds_pool[1] = '1;
    mem_pool[0] = '0;
    mem_pool[1] = '1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: misses on an empty cache, extremes, hit, stale, get, invalidate
    r = '{vlsc_pkg::OP_LOOKUP, '0, '0, '0, '0, '0, '0, '0, '0};
    pending_reqs.push_back(r);
    r.op = vlsc_pkg::OP_GET;
    pending_reqs.push_back(r);
    r.op = vlsc_pkg::OP_INVALIDATE;
    pending_reqs.push_back(r);
    r = '{vlsc_pkg::OP_PUT, '1, '1, '1, '1, '1, 32'h8000_0000, 32'h7fff_ffff, '1};
    pending_reqs.push_back(r);
    r.op = vlsc_pkg::OP_GET;
    pending_reqs.push_back(r);
    r.op = vlsc_pkg::OP_LOOKUP;
    pending_reqs.push_back(r);
    r.date = 32'h8000_0000;
    pending_reqs.push_back(r);
    r.op = vlsc_pkg::OP_GET;
    pending_reqs.push_back(r);
    r = '{vlsc_pkg::OP_PUT, '0, '0, 64'h5, 16'h8000, 8'h80, '1, '0, 32'd10};
    pending_reqs.push_back(r);
    r.size = 64'h6;
    r.now = 32'd11;
    pending_reqs.push_back(r);
    r.op = vlsc_pkg::OP_INVALIDATE;
    pending_reqs.push_back(r);
    pending_reqs.push_back(r);
    // fill the cache, then overflow it to force eviction with tied stamps
    for (int i = 0; i < Slots + 3; i++) begin
      r = '{vlsc_pkg::OP_PUT, 64'(i), 64'hA5, 64'(i), '0, '0, '0, '0, 32'(i / 2)};
      pending_reqs.push_back(r);
    end
    r = '{vlsc_pkg::OP_GET, 64'd2, 64'hA5, '0, '0, '0, '0, '0, '0};
    pending_reqs.push_back(r);
    r.dataset = 64'd6;
    pending_reqs.push_back(r);
    // clear out the filler so random keys find room
    for (int i = 0; i < Slots + 3; i++) begin
      r = '{vlsc_pkg::OP_INVALIDATE, 64'(i), 64'hA5, '0, '0, '0, '0, '0, '0};
      pending_reqs.push_back(r);
    end

    // random traffic, time mostly advancing with occasional jumps to a random value
    clock_now = 32'd100;
    for (int i = 0; i < 1500; i++) begin
      if ($urandom_range(19, 0) == 0) clock_now = $urandom();
      else clock_now += $urandom_range(3, 0);
      pending_reqs.push_back(random_request(clock_now));
    end
    stimulus_done = 1'b1;
  end

  // driver: bursts with random gaps
  int unsigned burst_left;
  int unsigned gap_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_op <= '0;
      in_dataset_tag <= '0;
      in_member_tag <= '0;
      in_size_value <= '0;
      in_first_track <= '0;
      in_first_record <= '0;
      in_line_count <= '0;
      in_change_date <= '0;
      in_now_seconds <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0 || pending_reqs.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        request_t r;
        r = pending_reqs.pop_front();
        expected_replies.push_back(cache_response(r));
        in_valid <= 1'b1;
        in_op <= r.op;
        in_dataset_tag <= r.dataset;
        in_member_tag <= r.member;
        in_size_value <= r.size;
        in_first_track <= r.track;
        in_first_record <= r.record;
        in_line_count <= r.lines;
        in_change_date <= r.date;
        in_now_seconds <= r.now;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(8, 1);
          gap_left <= ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(300, 0);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // receiver stall pattern: long ready phases alternating with random stalls
  int unsigned stall_phase;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (stall_phase[9]) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(3, 0) != 0);
    end
  end

  // monitor: compare each result beat with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_replies.size() == 0) begin
        $error("result beat with no prediction waiting");
        errors++;
      end else begin
        reply_t e;
        e = expected_replies.pop_front();
        if (out_status !== e.status) begin
          $error("status: expected %0d got %0d", e.status, out_status); errors++;
        end
        if (out_cached_size !== e.size) begin
          $error("cached_size: expected %h got %h", e.size, out_cached_size); errors++;
        end
        if (out_cached_track !== e.track) begin
          $error("cached_track: expected %h got %h", e.track, out_cached_track); errors++;
        end
        if (out_cached_record !== e.record) begin
          $error("cached_record: expected %h got %h", e.record, out_cached_record); errors++;
        end
        if (out_cached_lines !== e.lines) begin
          $error("cached_lines: expected %h got %h", e.lines, out_cached_lines); errors++;
        end
        if (out_cached_date !== e.date) begin
          $error("cached_date: expected %h got %h", e.date, out_cached_date); errors++;
        end
        if (out_entry_count !== e.count) begin
          $error("entry_count: expected %0d got %0d", e.count, out_entry_count); errors++;
        end
      end
    end
  end

  // end of run and watchdog
  initial begin
    int unsigned idle;
    errors = 0;
    idle = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
      if (idle >= IdleLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
      if (stimulus_done && pending_reqs.size() == 0 && !in_valid &&
          expected_replies.size() == 0) begin
        repeat (2 * Slots + 10) @(posedge clk);
        if (errors == 0) begin
          $display("Simulation PASSED");
        end else begin
          $display("Simulation FAILED");
        end
        $finish;
      end
    end
  end

endmodule
